@@ hw/rtl/dms_pkg.sv @@
// Shared types, codes and lookup functions for the device mode sequencer.
// No dependencies; compile first.
`default_nettype none

package dms_pkg;

	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [9:0]  MS_PER_S = 10'd1000;
	localparam logic [15:0] SAT16    = 16'hFFFF;

	// reset values of the configuration registers
	localparam logic [15:0] RST_DEBOUNCE_MS = 16'd200;
	localparam logic [15:0] RST_OFF_HOLD_MS = 16'd2000;
	localparam logic [15:0] RST_ON_HOLD_MS  = 16'd1000;
	localparam logic [15:0] RST_IDLE_OFF_S  = 16'd180;
	localparam logic [15:0] RST_DIAG_TO_S   = 16'd300;
	localparam logic [15:0] RST_SESS_TO_S   = 16'd1800;
	localparam logic [15:0] RST_PHASE_A_S   = 16'd300;
	localparam logic [15:0] RST_PHASE_B_S   = 16'd1500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_MS = 4'd0,
		CFG_OFF_HOLD_MS = 4'd1,
		CFG_ON_HOLD_MS  = 4'd2,
		CFG_IDLE_OFF_S  = 4'd3,
		CFG_DIAG_TO_S   = 4'd4,
		CFG_SESS_TO_S   = 4'd5,
		CFG_PHASE_A_S   = 4'd6,
		CFG_PHASE_B_S   = 4'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_OFF  = 3'd0,
		MODE_ON   = 3'd1,
		MODE_DIAG = 3'd2,
		MODE_T1   = 3'd3,
		MODE_T2   = 3'd4,
		MODE_T3   = 3'd5,
		MODE_4A   = 3'd6,
		MODE_4B   = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		KEY_NONE = 2'd0,
		KEY_SYS  = 2'd1,
		KEY_DIAG = 2'd2,
		KEY_MODE = 2'd3
	} key_t;

	typedef enum logic [1:0] {
		BEEP_PWR_OFF = 2'd0,
		BEEP_ON      = 2'd1,
		BEEP_CHANGE  = 2'd2
	} beep_t;

	typedef enum logic [2:0] {
		LED_OFF       = 3'd0,
		LED_RED       = 3'd1,
		LED_GREEN     = 3'd2,
		LED_BLUE      = 3'd3,
		LED_TURQUOISE = 3'd4,
		LED_YELLOW    = 3'd5,
		LED_PURPLE    = 3'd6
	} led_t;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] off_hold_ms;
		logic [15:0] on_hold_ms;
		logic [15:0] idle_off_s;
		logic [15:0] diag_timeout_s;
		logic [15:0] session_timeout_s;
		logic [15:0] phase_a_s;
		logic [15:0] phase_b_s;
	} cfg_regs_t;

	// classified tick passed from the front queue to the back
	typedef struct packed {
		logic valid;
		key_t key;
	} key_word_t;

	typedef struct packed {
		mode_t mode_now;
		led_t  led_colour;
		logic  mcu_enable;
		logic  laser_enable;
		logic  synth_enable;
		logic  sound_enable;
		logic  optical_enable;
		logic  beep_request;
		beep_t beep_kind;
		logic  sensor_restart;
		key_t  held_key;
	} result_t;

	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (v == SAT16) ? SAT16 : v + 16'd1;
	endfunction

	function automatic led_t led_of_mode(input mode_t m);
		led_t l;
		case (m)
			MODE_OFF:  l = LED_OFF;
			MODE_ON:   l = LED_GREEN;
			MODE_DIAG: l = LED_BLUE;
			MODE_T1:   l = LED_RED;
			MODE_T2:   l = LED_PURPLE;
			MODE_T3:   l = LED_TURQUOISE;
			MODE_4A:   l = LED_PURPLE;
			MODE_4B:   l = LED_YELLOW;
			default:   l = LED_OFF;
		endcase
		return l;
	endfunction

	// bit4 mcu, bit3 laser, bit2 synth, bit1 sound, bit0 optical
	function automatic logic [4:0] pwr_of_mode(input mode_t m);
		logic [4:0] p;
		case (m)
			MODE_OFF:  p = 5'h00;
			MODE_ON:   p = 5'h10;
			MODE_DIAG: p = 5'h11;
			MODE_T1:   p = 5'h18;
			MODE_T2:   p = 5'h14;
			MODE_T3:   p = 5'h1E;
			MODE_4A:   p = 5'h1F;
			MODE_4B:   p = 5'h1E;
			default:   p = 5'h00;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dms_if.sv @@
// Channel interfaces of the device mode sequencer: tick input, result output
// and configuration write. Depends on dms_pkg.
`default_nettype none

interface dms_req_if;
	logic valid;
	logic ready;
	logic sys_button_n;
	logic diag_button_n;
	logic mode_button_n;

	modport source (output valid, sys_button_n, diag_button_n, mode_button_n, input ready);
	modport sink   (input valid, sys_button_n, diag_button_n, mode_button_n, output ready);
endinterface

interface dms_rsp_if;
	import dms_pkg::*;
	logic       valid;
	logic       ready;
	logic [2:0] mode_now;
	logic [2:0] led_colour;
	logic       mcu_enable;
	logic       laser_enable;
	logic       synth_enable;
	logic       sound_enable;
	logic       optical_enable;
	logic       beep_request;
	logic [1:0] beep_kind;
	logic       sensor_restart;
	logic [1:0] held_key;

	modport source (output valid, mode_now, led_colour, mcu_enable, laser_enable,
		synth_enable, sound_enable, optical_enable, beep_request, beep_kind,
		sensor_restart, held_key, input ready);
	modport sink   (input valid, mode_now, led_colour, mcu_enable, laser_enable,
		synth_enable, sound_enable, optical_enable, beep_request, beep_kind,
		sensor_restart, held_key, output ready);
endinterface

interface dms_cfg_if;
	import dms_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dms_front.sv @@
// Front end: accepts tick words, resolves the key by priority and queues it.
// Depends on dms_pkg and dms_if.
`default_nettype none

module dms_front (
	input  logic              clk,
	input  logic              arst_n,
	dms_req_if.sink           req,
	output dms_pkg::key_word_t word,
	input  logic              take
);
	import dms_pkg::*;

	key_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	key_t              req_key;
	logic              push;

	// system beats diagnostic beats mode
	always_comb begin
		if (!req.sys_button_n)       req_key = KEY_SYS;
		else if (!req.diag_button_n) req_key = KEY_DIAG;
		else if (!req.mode_button_n) req_key = KEY_MODE;
		else                         req_key = KEY_NONE;
	end

	assign req.ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign word      = '{valid: (count_q != '0), key: fifo_q[rd_ptr_q]};

	// store queued keys
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= req_key;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (take) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !take)      count_q <= count_q + QCNT_W'(1);
			else if (take && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dms_back.sv @@
// Back end: holds configuration and sequencer state, executes one tick per
// cycle unless rsp stalls, registers the result word; needs dms_pkg, dms_if.
`default_nettype none

module dms_back (
	input  logic              clk,
	input  logic              arst_n,
	dms_cfg_if.sink           cfg,
	input  dms_pkg::key_word_t word,
	output logic              take,
	dms_rsp_if.source         rsp
);
	import dms_pkg::*;

	cfg_regs_t   cfg_q;
	mode_t       mode_q,  mode_n;
	key_t        key_q,   key_n;
	logic        busy_q,  busy_n;
	logic [15:0] deb_q,   deb_n;
	logic [15:0] hold_q,  hold_n;
	logic [9:0]  ms_q,    ms_n;
	logic [15:0] msec_q,  msec_n;
	logic [15:0] idle_q,  idle_n;
	mode_t       handled;
	logic        beep;
	beep_t       kind;
	logic        restart;
	logic [4:0]  pwr;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;

	assign cfg.ready = 1'b1;
	assign take      = word.valid && (!out_valid_q || rsp.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms       <= RST_DEBOUNCE_MS;
			cfg_q.off_hold_ms       <= RST_OFF_HOLD_MS;
			cfg_q.on_hold_ms        <= RST_ON_HOLD_MS;
			cfg_q.idle_off_s        <= RST_IDLE_OFF_S;
			cfg_q.diag_timeout_s    <= RST_DIAG_TO_S;
			cfg_q.session_timeout_s <= RST_SESS_TO_S;
			cfg_q.phase_a_s         <= RST_PHASE_A_S;
			cfg_q.phase_b_s         <= RST_PHASE_B_S;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEBOUNCE_MS: cfg_q.debounce_ms       <= cfg.data;
				CFG_OFF_HOLD_MS: cfg_q.off_hold_ms       <= cfg.data;
				CFG_ON_HOLD_MS:  cfg_q.on_hold_ms        <= cfg.data;
				CFG_IDLE_OFF_S:  cfg_q.idle_off_s        <= cfg.data;
				CFG_DIAG_TO_S:   cfg_q.diag_timeout_s    <= cfg.data;
				CFG_SESS_TO_S:   cfg_q.session_timeout_s <= cfg.data;
				CFG_PHASE_A_S:   cfg_q.phase_a_s         <= cfg.data;
				CFG_PHASE_B_S:   cfg_q.phase_b_s         <= cfg.data;
				default: ;
			endcase
		end
	end

	// one tick: sample key, count, expire debounce, second boundary, mode step
	always_comb begin
		busy_n  = busy_q;
		key_n   = key_q;
		hold_n  = hold_q;
		deb_n   = deb_q;
		msec_n  = msec_q;
		idle_n  = idle_q;
		mode_n  = mode_q;
		beep    = 1'b0;
		kind    = BEEP_PWR_OFF;
		restart = 1'b0;

		if (!busy_n) begin
			busy_n = 1'b1;
			key_n  = word.key;
			if (word.key == KEY_NONE) begin
				busy_n = 1'b0;
				hold_n = '0;
			end
		end

		ms_n = ms_q + 10'd1;
		if (key_n != KEY_NONE) hold_n = inc_sat(hold_n);
		if (busy_n) deb_n = inc_sat(deb_n);

		if (deb_n > cfg_q.debounce_ms) begin
			busy_n = 1'b0;
			deb_n  = '0;
		end

		if (ms_n >= MS_PER_S) begin
			if (mode_n > MODE_ON) msec_n = inc_sat(msec_n);
			if (idle_n > cfg_q.idle_off_s) begin
				mode_n = MODE_OFF;
				beep   = 1'b1;
				kind   = BEEP_PWR_OFF;
			end
			ms_n = '0;
			if (mode_n == MODE_ON && key_n == KEY_NONE) idle_n = inc_sat(idle_n);
			else idle_n = '0;
		end

		handled = mode_n;
		case (handled)
			MODE_OFF: begin
				if (key_n == KEY_SYS && hold_n > cfg_q.on_hold_ms) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_ON;
					hold_n = '0;
				end
			end
			MODE_ON: begin
				if (key_n == KEY_SYS && hold_n > cfg_q.off_hold_ms) begin
					mode_n = MODE_OFF;
					beep   = 1'b1;
					kind   = BEEP_PWR_OFF;
					hold_n = '0;
				end else if (key_n == KEY_DIAG) begin
					mode_n  = MODE_DIAG;
					msec_n  = '0;
					beep    = 1'b1;
					kind    = BEEP_CHANGE;
					restart = 1'b1;
				end else if (key_n == KEY_MODE) begin
					mode_n = MODE_T1;
					msec_n = '0;
					key_n  = KEY_NONE;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end
			end
			MODE_DIAG: begin
				if (key_n == KEY_SYS || msec_n > cfg_q.diag_timeout_s) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end
			end
			MODE_T1, MODE_T2, MODE_T3: begin
				if (key_n == KEY_SYS) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end else if (key_n == KEY_MODE) begin
					mode_n = mode_t'(3'(handled + 3'd1));
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
					key_n  = KEY_NONE;
					if (handled == MODE_T3) restart = 1'b1;
				end
				if (msec_n > cfg_q.session_timeout_s) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end
			end
			MODE_4A: begin
				if (key_n == KEY_SYS) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end else if (key_n == KEY_MODE) begin
					mode_n = MODE_T1;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
					key_n  = KEY_NONE;
				end
				// phase timeout overrides the key, its beep stays
				if (msec_n > cfg_q.phase_a_s) mode_n = MODE_4B;
			end
			default: begin
				if (key_n == KEY_SYS) begin
					mode_n = MODE_ON;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
				end else if (key_n == KEY_MODE) begin
					mode_n = MODE_T1;
					beep   = 1'b1;
					kind   = BEEP_CHANGE;
					key_n  = KEY_NONE;
				end
				if (msec_n > cfg_q.phase_b_s) begin
					mode_n  = MODE_4A;
					restart = 1'b1;
				end
			end
		endcase

		pwr                = pwr_of_mode(handled);
		res.mode_now       = mode_n;
		res.led_colour     = led_of_mode(handled);
		res.mcu_enable     = pwr[4];
		res.laser_enable   = pwr[3];
		res.synth_enable   = pwr[2];
		res.sound_enable   = pwr[1];
		res.optical_enable = pwr[0];
		res.beep_request   = beep;
		res.beep_kind      = beep ? kind : BEEP_PWR_OFF;
		res.sensor_restart = restart;
		res.held_key       = key_n;
	end

	// commit state on each executed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			key_q  <= KEY_NONE;
			busy_q <= 1'b0;
			deb_q  <= '0;
			hold_q <= '0;
			ms_q   <= '0;
			msec_q <= '0;
			idle_q <= '0;
		end else if (take) begin
			mode_q <= mode_n;
			key_q  <= key_n;
			busy_q <= busy_n;
			deb_q  <= deb_n;
			hold_q <= hold_n;
			ms_q   <= ms_n;
			msec_q <= msec_n;
			idle_q <= idle_n;
		end
	end

	// output word register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.mode_now       = out_q.mode_now;
	assign rsp.led_colour     = out_q.led_colour;
	assign rsp.mcu_enable     = out_q.mcu_enable;
	assign rsp.laser_enable   = out_q.laser_enable;
	assign rsp.synth_enable   = out_q.synth_enable;
	assign rsp.sound_enable   = out_q.sound_enable;
	assign rsp.optical_enable = out_q.optical_enable;
	assign rsp.beep_request   = out_q.beep_request;
	assign rsp.beep_kind      = out_q.beep_kind;
	assign rsp.sensor_restart = out_q.sensor_restart;
	assign rsp.held_key       = out_q.held_key;

endmodule

`default_nettype wire

@@ hw/rtl/device_mode_sequencer.sv @@
// Device mode sequencer.
// Channels: req carries one 1 ms tick per word with the three active-low
// button levels; rsp returns exactly one result word per tick (mode after
// the tick, LED colour and power enables of the handled mode, beep request
// and kind, sensor restart, latched key); cfg writes the eight 16-bit
// timing registers by index and is always ready. Write cfg only while idle.
// An accepted tick is queued in the front, executed in the back, and its
// result word is registered. Throughput: one tick per clock while rsp keeps
// up. A two-word key queue sits between front and back, and the result
// word is registered, so req stays ready while a result waits on rsp until
// the queue fills. When rsp stalls, the result holds, the queue fills and
// req.ready drops once it holds two words.
// Reset: mode off, no key latched, all counters zero, registers at their
// default timings; the queue and result register are empty.
// Depends on dms_pkg, dms_if, dms_front and dms_back.
`default_nettype none

module device_mode_sequencer (
	input  logic      clk,
	input  logic      arst_n,
	dms_cfg_if.sink   cfg,
	dms_req_if.sink   req,
	dms_rsp_if.source rsp
);
	import dms_pkg::*;

	key_word_t word;
	logic      take;

	dms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.word   (word),
		.take   (take)
	);

	dms_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.word   (word),
		.take   (take),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	// no beep means the kind field is cleared
	a_beep_kind_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.beep_request |-> rsp.beep_kind == BEEP_PWR_OFF)
		else $error("beep_kind set without beep_request");

	// the power-on beep only ever lands in on mode
	a_beep_on_mode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.beep_request && rsp.beep_kind == BEEP_ON
		|-> rsp.mode_now == MODE_ON)
		else $error("power-on beep outside on mode");

	// with the main supply dropped nothing else may be powered
	a_power_off_all: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.mcu_enable
		|-> !rsp.laser_enable && !rsp.synth_enable && !rsp.sound_enable
			&& !rsp.optical_enable && rsp.led_colour == LED_OFF)
		else $error("supply enabled while main power is off");
`endif

endmodule

`default_nettype wire
